// ----- src/cfrx_pkg.sv -----
// Package for the chunked frame receiver.
// Holds the phase type, result status codes and framing constants.
// No dependencies.
`timescale 1ns / 1ps

package cfrx_pkg;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SECOND = 2'd1,
        PH_TOTAL  = 2'd2,
        PH_RECV   = 2'd3
    } t_phase;

    typedef logic [2:0] t_status;

    localparam t_status ST_NONE      = 3'd0;
    localparam t_status ST_AVAILABLE = 3'd1;
    localparam t_status ST_RECEIVING = 3'd2;
    localparam t_status ST_READY     = 3'd3;
    localparam t_status ST_ERROR     = 3'd4;

    localparam logic [7:0] SYNC_FIRST  = 8'h28;
    localparam logic [7:0] SYNC_SECOND = 8'h39;
    localparam int unsigned ADDR_SPAN  = 1024;
    localparam int unsigned ADDR_W     = 10;

endpackage

// ----- src/chunked_frame_receiver_xor_ack.sv -----
// Chunked frame receiver with per-chunk XOR acknowledge, top level.
// Uses cfrx_pkg for phase type, status codes and sync constants.
`timescale 1ns / 1ps

// One beat in, one result beat out. Each input beat (a received byte or a
// timing tick) is decoded combinationally against the frame state and its
// result lands in the output register; a new beat is taken every cycle as
// long as the output register is empty or is being drained in that cycle, so
// the sustained rate is one beat per clock. Header sync is 0x28 then 0x39,
// then a total byte (reported times four), then length-prefixed chunks; a
// zero length ends the frame. Buffer writes stop one slot short of
// min(BUFFER_DEPTH, 1024) to keep room for the terminator.
module chunked_frame_receiver_xor_ack #(
    parameter int unsigned BUFFER_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [15:0]          i_cfg_wr_data,  // timeout_ticks
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic                 s_axis_tuser,   // [0] func: 0 byte, 1 tick
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] echo_valid, [8:1] echo_byte, [9] store_write, [19:10] store_addr,
    // [27:20] store_data, [37:28] total_count, [39:38] zero
    output logic [39:0]          m_axis_tdata,
    output cfrx_pkg::t_status    m_axis_tuser    // [2:0] status
);
    import cfrx_pkg::*;

    localparam int unsigned STORE_LIMIT =
        (BUFFER_DEPTH > ADDR_SPAN) ? ADDR_SPAN : BUFFER_DEPTH;
    localparam logic [ADDR_W:0] LIMIT_EXT = (ADDR_W + 1)'(STORE_LIMIT);

    logic [15:0]       r_timeout;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_remain, n_remain;
    logic [ADDR_W-1:0] r_windex, n_windex;
    logic [7:0]        r_xor, n_xor;
    logic [15:0]       r_idle, n_idle;

    logic              r_out_valid;
    t_status           r_status, n_status;
    logic              r_ev, n_ev;
    logic [7:0]        r_eb, n_eb;
    logic              r_sw, n_sw;
    logic [ADDR_W-1:0] r_sa, n_sa;
    logic [7:0]        r_sd, n_sd;
    logic [ADDR_W-1:0] r_tc, n_tc;

    logic              in_fire;
    logic [15:0]       lim;
    logic [15:0]       idle_inc;
    logic [7:0]        rx_byte;
    logic [7:0]        xor_next;
    logic [7:0]        remain_dec;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign rx_byte       = s_axis_tdata;
    assign lim           = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    assign idle_inc      = r_idle + 16'd1;
    assign xor_next      = r_xor ^ rx_byte;
    assign remain_dec    = r_remain - 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_remain = r_remain;
        n_windex = r_windex;
        n_xor    = r_xor;
        n_idle   = r_idle;
        n_status = ST_NONE;
        n_ev     = 1'b0;
        n_eb     = '0;
        n_sw     = 1'b0;
        n_sa     = '0;
        n_sd     = '0;
        n_tc     = '0;
        if (s_axis_tuser) begin
            if (r_phase == PH_HUNT) begin
                n_idle = '0;
            end else if (idle_inc >= lim) begin
                n_idle = '0;
                if (r_phase == PH_RECV) begin
                    n_status = ST_ERROR;
                end
            end else begin
                n_idle = idle_inc;
            end
        end else begin
            n_idle = '0;
            unique case (r_phase)
                PH_HUNT: begin
                    if (rx_byte == SYNC_FIRST) begin
                        n_phase = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    if (rx_byte == SYNC_SECOND) begin
                        n_phase = PH_TOTAL;
                    end
                end
                PH_TOTAL: begin
                    n_tc     = {rx_byte, 2'b00};
                    n_phase  = PH_RECV;
                    n_status = ST_AVAILABLE;
                end
                default: begin
                    if (r_remain == 8'd0) begin
                        if (rx_byte == 8'd0) begin
                            n_sw     = 1'b1;
                            n_sa     = r_windex;
                            n_tc     = r_windex;
                            n_windex = '0;
                            n_phase  = PH_HUNT;
                            n_status = ST_READY;
                        end else begin
                            n_remain = rx_byte;
                            n_xor    = '0;
                            n_status = ST_RECEIVING;
                        end
                    end else begin
                        if (({1'b0, r_windex} + 1'b1) < LIMIT_EXT) begin
                            n_status = ST_RECEIVING;
                            n_sw     = 1'b1;
                            n_sa     = r_windex;
                            n_sd     = rx_byte;
                            n_windex = r_windex + 1'b1;
                        end else begin
                            n_status = ST_ERROR;
                        end
                        n_xor    = xor_next;
                        n_remain = remain_dec;
                        if (remain_dec == 8'd0) begin
                            n_ev = 1'b1;
                            n_eb = xor_next;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= 16'd100;
            r_phase     <= PH_HUNT;
            r_remain    <= '0;
            r_windex    <= '0;
            r_xor       <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_phase  <= n_phase;
                r_remain <= n_remain;
                r_windex <= n_windex;
                r_xor    <= n_xor;
                r_idle   <= n_idle;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status <= n_status;
            r_ev     <= n_ev;
            r_eb     <= n_eb;
            r_sw     <= n_sw;
            r_sa     <= n_sa;
            r_sd     <= n_sd;
            r_tc     <= n_tc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {2'b00, r_tc, r_sd, r_sa, r_sw, r_eb, r_ev};

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted beat produced no result");

    a_error_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_ERROR) |-> !r_sw)
        else $error("error result also wrote the buffer");

    a_echo_in_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev) |-> (r_status == ST_RECEIVING || r_status == ST_ERROR))
        else $error("echo outside a chunk payload beat");

    a_ready_terminator: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_READY) |-> (r_sw && r_sd == 8'd0 && r_sa == r_tc))
        else $error("frame end without matching terminator write");

    a_windex_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_windex} < LIMIT_EXT))
        else $error("write index past buffer limit");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for chunked_frame_receiver_xor_ack: drives bytes and ticks,
// predicts every result beat in a scoreboard class and compares it field by field.
// Depends on cfrx_pkg and the RTL top level only.

module tb;
    import cfrx_pkg::*;

    localparam int BUF_DEPTH   = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam bit FN_BYTE     = 1'b0;
    localparam bit FN_TICK     = 1'b1;

    typedef struct packed {
        t_status    status;
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       store_write;
        logic [9:0] store_addr;
        logic [7:0] store_data;
        logic [9:0] total_count;
    } t_ack_result;

    class ack_scoreboard;
        localparam int STORE_LIMIT = (BUF_DEPTH < ADDR_SPAN) ? BUF_DEPTH : ADDR_SPAN;

        t_phase      phase;
        logic [7:0]  chunk_left;
        logic [9:0]  wr_index;
        logic [7:0]  xor_acc;
        logic [15:0] idle_ticks;
        logic [9:0]  total_len;
        logic [15:0] timeout;
        t_ack_result owed[$];
        int          errors;

        function new();
            phase      = PH_HUNT;
            chunk_left = '0;
            wr_index   = '0;
            xor_acc    = '0;
            idle_ticks = '0;
            total_len  = '0;
            timeout    = 16'd100;
            errors     = 0;
        endfunction

        function void accept_rx(bit func, logic [7:0] b);
            t_ack_result r;
            logic [15:0] lim;
            r = '0;
            r.status = ST_NONE;
            if (func == FN_TICK) begin
                if (phase == PH_HUNT) begin
                    idle_ticks = '0;
                end else begin
                    lim = (timeout == 16'd0) ? 16'd1 : timeout;
                    idle_ticks = idle_ticks + 16'd1;
                    if (idle_ticks >= lim) begin
                        idle_ticks = '0;
                        if (phase == PH_RECV) r.status = ST_ERROR;
                    end
                end
            end else begin
                idle_ticks = '0;
                case (phase)
                    PH_HUNT: begin
                        if (b == SYNC_FIRST) phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        if (b == SYNC_SECOND) phase = PH_TOTAL;
                    end
                    PH_TOTAL: begin
                        total_len = {b, 2'b00};
                        r.total_count = total_len;
                        r.status = ST_AVAILABLE;
                        phase = PH_RECV;
                    end
                    default: begin
                        if (chunk_left == 8'd0) begin
                            if (b == 8'd0) begin
                                r.store_write = 1'b1;
                                r.store_addr  = wr_index;
                                r.store_data  = 8'd0;
                                total_len     = wr_index;
                                r.total_count = total_len;
                                r.status      = ST_READY;
                                wr_index      = '0;
                                phase         = PH_HUNT;
                            end else begin
                                chunk_left = b;
                                xor_acc    = '0;
                                r.status   = ST_RECEIVING;
                            end
                        end else begin
                            r.status = ST_RECEIVING;
                            if (int'(wr_index) + 1 < STORE_LIMIT) begin
                                r.store_write = 1'b1;
                                r.store_addr  = wr_index;
                                r.store_data  = b;
                                wr_index      = wr_index + 10'd1;
                            end else begin
                                r.status = ST_ERROR;
                            end
                            xor_acc    = xor_acc ^ b;
                            chunk_left = chunk_left - 8'd1;
                            if (chunk_left == 8'd0) begin
                                r.echo_valid = 1'b1;
                                r.echo_byte  = xor_acc;
                            end
                        end
                    end
                endcase
            end
            owed.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task compare(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_beat(logic [39:0] d, t_status st);
            t_ack_result w;
            if (owed.size() == 0) begin
                report("result beat with nothing outstanding");
                return;
            end
            w = owed.pop_front();
            compare("status", 16'(st), 16'(w.status));
            compare("echo_valid", 16'(d[0]), 16'(w.echo_valid));
            compare("echo_byte", 16'(d[8:1]), 16'(w.echo_byte));
            compare("store_write", 16'(d[9]), 16'(w.store_write));
            compare("store_addr", 16'(d[19:10]), 16'(w.store_addr));
            compare("store_data", 16'(d[27:20]), 16'(w.store_data));
            compare("total_count", 16'(d[37:28]), 16'(w.total_count));
            compare("pad", 16'(d[39:38]), 16'd0);
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    t_status     m_axis_tuser;

    ack_scoreboard sb = new();
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int beats    = 0;
    int quiet    = 0;

    chunked_frame_receiver_xor_ack #(.BUFFER_DEPTH(BUF_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hold off the result side on request, otherwise stall at random while idle_on is set
    always begin
        @(posedge i_clk);
        if (hold_req) begin
            hold_req = 1'b0;
            m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
        end
        m_axis_tready <= !idle_on || ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("chunked_frame_receiver_xor_ack: mismatch");
            $finish;
        end
    end

    task automatic send_beat(bit func, logic [7:0] b);
        while (idle_on && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.accept_rx(func, b);
        beats++;
    endtask

    task automatic send_ticks(int pct);
        if ($urandom_range(99) < pct) begin
            repeat ($urandom_range(1, 4)) send_beat(FN_TICK, 8'($urandom_range(255)));
        end
    endtask

    // break_pm: per-mille chance of abandoning the frame before each payload beat
    task automatic send_frame(int n_chunks, int min_len, int max_len, int break_pm,
                              int tick_pct);
        int len;
        send_beat(FN_BYTE, SYNC_FIRST);
        send_ticks(tick_pct);
        send_beat(FN_BYTE, SYNC_SECOND);
        send_ticks(tick_pct);
        send_beat(FN_BYTE, 8'($urandom_range(255)));
        for (int c = 0; c < n_chunks; c++) begin
            len = $urandom_range(min_len, max_len);
            send_ticks(tick_pct);
            send_beat(FN_BYTE, 8'(len));
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(999) < break_pm) return;
                send_ticks(tick_pct);
                send_beat(FN_BYTE, 8'($urandom_range(255)));
            end
        end
        send_ticks(tick_pct);
        send_beat(FN_BYTE, 8'h00);
    endtask

    task automatic spray_noise();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(9))
                0, 1, 2: send_beat(FN_TICK, 8'($urandom_range(255)));
                3, 4:    send_beat(FN_BYTE, SYNC_FIRST);
                default: send_beat(FN_BYTE, 8'($urandom_range(255)));
            endcase
        end
    endtask

    task automatic run_traffic(int n_items, int tick_pct);
        int target;
        target = beats + n_items;
        while (beats < target) begin
            if ($urandom_range(99) < 80)
                send_frame($urandom_range(4), 1, ($urandom_range(9) == 0) ? 60 : 10, 15,
                           tick_pct);
            else
                spray_noise();
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [15:0] v);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.timeout = v;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // header hunt, ignored bytes, max total, short chunks, empty frame
        send_beat(FN_TICK, 8'hFF);
        send_beat(FN_BYTE, 8'h00);
        send_beat(FN_BYTE, SYNC_FIRST);
        send_beat(FN_BYTE, 8'h00);
        send_beat(FN_BYTE, SYNC_FIRST);
        send_beat(FN_BYTE, SYNC_SECOND);
        send_beat(FN_BYTE, 8'hFF);
        send_beat(FN_BYTE, 8'd1);
        send_beat(FN_BYTE, 8'hA5);
        send_beat(FN_BYTE, 8'd2);
        send_beat(FN_BYTE, 8'h00);
        send_beat(FN_BYTE, 8'hFF);
        send_beat(FN_BYTE, 8'h00);
        send_beat(FN_BYTE, SYNC_FIRST);
        send_beat(FN_BYTE, SYNC_SECOND);
        send_beat(FN_BYTE, 8'h00);
        send_beat(FN_BYTE, 8'h00);

        // expire waits in every phase past the hunt
        set_timeout(16'd1);
        send_beat(FN_BYTE, SYNC_FIRST);
        send_beat(FN_TICK, 8'h00);
        send_beat(FN_BYTE, SYNC_SECOND);
        send_beat(FN_TICK, 8'h00);
        send_beat(FN_BYTE, 8'h80);
        send_beat(FN_TICK, 8'h00);
        send_beat(FN_BYTE, 8'd3);
        send_beat(FN_BYTE, 8'h5A);
        send_beat(FN_TICK, 8'h00);
        send_beat(FN_BYTE, 8'hC3);
        send_beat(FN_BYTE, 8'h3C);
        send_beat(FN_BYTE, 8'h00);

        // overrun the buffer while the result side holds off
        set_timeout(16'hFFFF);
        hold_req = 1'b1;
        send_frame(5, 206, 210, 0, 2);

        set_timeout(16'h0000);
        run_traffic(200, 10);

        set_timeout(16'd5);
        idle_on = 1'b0;
        run_traffic(200, 15);
        idle_on = 1'b1;

        set_timeout(16'd1);
        run_traffic(200, 10);

        set_timeout(16'd2);
        run_traffic(200, 10);

        settle();
        if (sb.errors == 0)
            $display("chunked_frame_receiver_xor_ack: match");
        else
            $display("chunked_frame_receiver_xor_ack: mismatch");
        $finish;
    end

endmodule
